[hw/rtl/ptw_pkg.sv]
// Shared types, codes and widths for the two-level page table walker.
`timescale 1ns / 1ps
`default_nettype none

package ptw_pkg;

  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned KIND_W  = 3;
  localparam int unsigned PHASE_W = 2;
  localparam int unsigned CFG_IDX_W = 2;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_FETCH  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_DONE   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_FAULT1 = 3'd2;
  localparam logic [KIND_W-1:0] KIND_FAULT2 = 3'd3;
  localparam logic [KIND_W-1:0] KIND_PROTO  = 3'd4;

  // Walk phases; the fourth code behaves as idle
  localparam logic [PHASE_W-1:0] PHASE_IDLE   = 2'd0;
  localparam logic [PHASE_W-1:0] PHASE_L1     = 2'd1;
  localparam logic [PHASE_W-1:0] PHASE_L2     = 2'd2;
  localparam logic [PHASE_W-1:0] PHASE_UNUSED = 2'd3;

  // Input opcodes
  localparam logic OP_TRANSLATE  = 1'b0;
  localparam logic OP_DESCRIPTOR = 1'b1;

  // Descriptor type codes
  localparam logic [1:0] DESC_FAULT   = 2'd0;
  localparam logic [1:0] DESC_COARSE  = 2'd1;
  localparam logic [1:0] DESC_SECTION = 2'd2;
  localparam logic [1:0] DESC_PASS    = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MMU_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TABLE_BASE = 2'd1;

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic [ADDR_W-1:0]  hva;
  } ptw_walk_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ADDR_W-1:0] address;
  } ptw_result_t;

  typedef struct packed {
    logic              opcode;
    logic [ADDR_W-1:0] virtual_address;
    logic [ADDR_W-1:0] descriptor_data;
  } ptw_item_t;

endpackage

`default_nettype wire

[hw/rtl/ptw_step.sv]
// Walk step decode: one item against the current walk state.
`timescale 1ns / 1ps
`default_nettype none

module ptw_step (
  input  wire ptw_pkg::ptw_item_t        item,
  input  wire ptw_pkg::ptw_walk_t        walk,
  input  wire                            mmu_enable,
  input  wire [ptw_pkg::ADDR_W-1:0]      table_base,
  output ptw_pkg::ptw_result_t           result,
  output ptw_pkg::ptw_walk_t             walk_next
);

  logic [ptw_pkg::PHASE_W-1:0] phase;
  logic [1:0]                  dtype;
  logic [ptw_pkg::ADDR_W-1:0]  hva;
  logic [ptw_pkg::ADDR_W-1:0]  desc;

  assign dtype = item.descriptor_data[1:0];
  assign hva   = walk.hva;
  assign desc  = item.descriptor_data;

  // Unused phase code folds to idle
  assign phase = (walk.phase == ptw_pkg::PHASE_UNUSED) ? ptw_pkg::PHASE_IDLE : walk.phase;

  always_comb begin
    walk_next.phase = ptw_pkg::PHASE_IDLE;
    walk_next.hva   = walk.hva;
    result.kind     = ptw_pkg::KIND_PROTO;
    result.address  = '0;
    if (item.opcode == ptw_pkg::OP_TRANSLATE) begin
      // New request: error mid-walk, passthrough when off, else first fetch
      if (phase != ptw_pkg::PHASE_IDLE) begin
        result.kind = ptw_pkg::KIND_PROTO;
      end else if (!mmu_enable) begin
        result.kind    = ptw_pkg::KIND_DONE;
        result.address = item.virtual_address;
      end else begin
        walk_next.hva   = item.virtual_address;
        walk_next.phase = ptw_pkg::PHASE_L1;
        result.kind     = ptw_pkg::KIND_FETCH;
        result.address  = table_base + {18'd0, item.virtual_address[31:20], 2'b00};
      end
    end else begin
      unique case (phase)
        ptw_pkg::PHASE_L1: begin
          unique case (dtype)
            ptw_pkg::DESC_FAULT: begin
              result.kind = ptw_pkg::KIND_FAULT1;
            end
            ptw_pkg::DESC_COARSE: begin
              walk_next.phase = ptw_pkg::PHASE_L2;
              result.kind     = ptw_pkg::KIND_FETCH;
              result.address  = {desc[31:10], hva[19:12], 2'b00};
            end
            ptw_pkg::DESC_SECTION: begin
              result.kind    = ptw_pkg::KIND_DONE;
              result.address = {desc[31:20], hva[19:0]};
            end
            default: begin
              // type 3 passes the held address through
              result.kind    = ptw_pkg::KIND_DONE;
              result.address = hva;
            end
          endcase
        end
        ptw_pkg::PHASE_L2: begin
          if (dtype == ptw_pkg::DESC_FAULT) begin
            result.kind = ptw_pkg::KIND_FAULT2;
          end else begin
            result.kind    = ptw_pkg::KIND_DONE;
            result.address = {desc[31:12], hva[11:0]};
          end
        end
        default: begin
          // descriptor while idle
          result.kind = ptw_pkg::KIND_PROTO;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[hw/rtl/two_level_page_table_walker.sv]
// Top level of the two-level page table walker.
// Usage:
//   s_axis carries one item per beat: tuser = opcode (0 translate request,
//   1 descriptor word back from memory), tdata = virtual_address then
//   descriptor_data. m_axis returns exactly one result per input beat:
//   tuser = result_kind, tdata = out_address (fetch address or physical
//   address, zero on a fault or protocol error). A fetch result asks the
//   host to read that word and feed it back as a descriptor beat.
//   The cfg channel writes mmu_enable (index 0) and table_base (index 1);
//   other indexes are dropped. cfg_ready is always high. Write only while
//   no walk is in flight.
// Timing: an item is taken into an input register, then decoded into the
//   result register once that register is free. One item per cycle while
//   m_axis does not stall; the walk state is updated by a single decode
//   step per item.
// Reset clears the walk state, both registers and both pipeline stages.
// When m_axis stalls, the result register holds and one more item may sit
//   in the input register; s_axis_tready drops only when both are full.
`timescale 1ns / 1ps
`default_nettype none

module two_level_page_table_walker (
  input  wire                               clk,
  input  wire                               rst,
  // input items
  input  wire                               s_axis_tvalid,
  output logic                              s_axis_tready,
  input  wire [63:0]                        s_axis_tdata,  // virtual_address, descriptor_data
  input  wire [0:0]                         s_axis_tuser,  // opcode
  // results
  output logic                              m_axis_tvalid,
  input  wire                               m_axis_tready,
  output logic [31:0]                       m_axis_tdata,  // out_address
  output logic [2:0]                        m_axis_tuser,  // result_kind
  // configuration writes
  input  wire                               cfg_valid,
  output logic                              cfg_ready,
  input  wire [ptw_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire [31:0]                        cfg_data
);

  logic                          mmu_enable;
  logic [ptw_pkg::ADDR_W-1:0]    table_base;
  ptw_pkg::ptw_walk_t            walk;
  ptw_pkg::ptw_walk_t            walk_next;
  ptw_pkg::ptw_item_t            in_item;
  logic                          in_valid;
  ptw_pkg::ptw_result_t          step_result;
  ptw_pkg::ptw_result_t          out_result;
  logic                          out_valid;
  logic                          advance;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mmu_enable <= 1'b0;
      table_base <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == ptw_pkg::REG_MMU_ENABLE) begin
        mmu_enable <= cfg_data[0];
      end else if (cfg_index == ptw_pkg::REG_TABLE_BASE) begin
        table_base <= cfg_data;
      end
    end
  end

  // Input register moves to the result register when that one frees up
  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item.opcode          <= s_axis_tuser[0];
      in_item.virtual_address <= s_axis_tdata[31:0];
      in_item.descriptor_data <= s_axis_tdata[63:32];
    end
  end

  ptw_step u_step (
    .item       (in_item),
    .walk       (walk),
    .mmu_enable (mmu_enable),
    .table_base (table_base),
    .result     (step_result),
    .walk_next  (walk_next)
  );

  // Walk state
  always_ff @(posedge clk) begin
    if (rst) begin
      walk.phase <= ptw_pkg::PHASE_IDLE;
      walk.hva   <= '0;
    end else if (advance) begin
      walk <= walk_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= step_result;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_result.address;
  assign m_axis_tuser  = out_result.kind;

  // Checks
  a_phase_used: assert property (@(posedge clk) disable iff (rst)
    walk.phase != ptw_pkg::PHASE_UNUSED)
    else $error("walk phase took the unused code");

  a_fault_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_result.kind == ptw_pkg::KIND_FAULT1 ||
                  out_result.kind == ptw_pkg::KIND_FAULT2 ||
                  out_result.kind == ptw_pkg::KIND_PROTO)
    |-> out_result.address == '0)
    else $error("fault or error result with nonzero address");

  a_fetch_walks: assert property (@(posedge clk) disable iff (rst)
    advance && step_result.kind == ptw_pkg::KIND_FETCH
    |=> walk.phase != ptw_pkg::PHASE_IDLE)
    else $error("fetch issued but walk left idle");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> in_valid && out_valid)
    else $error("input stalled with a free stage");

endmodule

`default_nettype wire

[bench/two_level_page_table_walker_checker.sv]
// Result checker for the page table walker: tracks the walk, predicts each result, compares.
`timescale 1ns / 1ps

module two_level_page_table_walker_checker
  import ptw_pkg::*;
(
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  s_axis_tvalid,
  input  wire                  s_axis_tready,
  input  wire [63:0]           s_axis_tdata,  // virtual_address, descriptor_data
  input  wire [0:0]            s_axis_tuser,  // opcode
  input  wire                  m_axis_tvalid,
  input  wire                  m_axis_tready,
  input  wire [31:0]           m_axis_tdata,  // out_address
  input  wire [2:0]            m_axis_tuser,  // result_kind
  input  wire                  cfg_valid,
  input  wire                  cfg_ready,
  input  wire [CFG_IDX_W-1:0]  cfg_index,
  input  wire [31:0]           cfg_data,
  output int                   mismatches,
  output int                   outstanding
);

  // shadow copy of the walker registers and walk state
  logic               mmu_on;
  logic [ADDR_W-1:0]  tbl_base;
  logic [PHASE_W-1:0] walk_phase;
  logic [ADDR_W-1:0]  held_va;

  ptw_result_t awaited_results[$];
  ptw_result_t exp_r;

  // one decode step of the walk; updates the shadow state
  function automatic ptw_result_t predict_walk_step(input logic op,
                                                    input logic [ADDR_W-1:0] va,
                                                    input logic [ADDR_W-1:0] desc);
    ptw_result_t        r;
    logic [1:0]         dtype;
    logic [PHASE_W-1:0] ph;
    ph = (walk_phase == PHASE_UNUSED) ? PHASE_IDLE : walk_phase;
    dtype = desc[1:0];
    r.kind = KIND_PROTO;
    r.address = '0;
    if (op == OP_TRANSLATE) begin
      if (ph != PHASE_IDLE) begin
        // request in the middle of a walk drops the walk
        walk_phase = PHASE_IDLE;
      end else if (!mmu_on) begin
        walk_phase = PHASE_IDLE;
        r.kind = KIND_DONE;
        r.address = va;
      end else begin
        held_va = va;
        walk_phase = PHASE_L1;
        r.kind = KIND_FETCH;
        r.address = tbl_base + {18'd0, va[31:20], 2'b00};
      end
    end else if (ph == PHASE_IDLE) begin
      // descriptor with no walk open
      walk_phase = PHASE_IDLE;
    end else if (ph == PHASE_L1) begin
      walk_phase = PHASE_IDLE;
      case (dtype)
        DESC_FAULT: begin
          r.kind = KIND_FAULT1;
        end
        DESC_COARSE: begin
          walk_phase = PHASE_L2;
          r.kind = KIND_FETCH;
          r.address = {desc[31:10], 10'd0} + {22'd0, held_va[19:12], 2'b00};
        end
        DESC_SECTION: begin
          r.kind = KIND_DONE;
          r.address = {desc[31:20], 20'd0} + {12'd0, held_va[19:0]};
        end
        default: begin
          r.kind = KIND_DONE;
          r.address = held_va;
        end
      endcase
    end else begin
      // second level
      walk_phase = PHASE_IDLE;
      if (dtype == DESC_FAULT) begin
        r.kind = KIND_FAULT2;
      end else begin
        r.kind = KIND_DONE;
        r.address = {desc[31:12], 12'd0} + {20'd0, held_va[11:0]};
      end
    end
    return r;
  endfunction

  task automatic flag_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%t mismatch: %s", $realtime, msg);
  endtask

  // result beats are matched before this edge's input beat is predicted
  always @(posedge clk) begin
    if (rst) begin
      mmu_on = 1'b0;
      tbl_base = '0;
      walk_phase = PHASE_IDLE;
      held_va = '0;
      mismatches = 0;
      awaited_results.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (awaited_results.size() == 0) begin
          flag_mismatch($sformatf("unexpected result kind %0d address %08h",
                                  m_axis_tuser, m_axis_tdata));
        end else begin
          exp_r = awaited_results.pop_front();
          if (m_axis_tuser !== exp_r.kind)
            flag_mismatch($sformatf("result_kind expected %0d got %0d",
                                    exp_r.kind, m_axis_tuser));
          if (m_axis_tdata !== exp_r.address)
            flag_mismatch($sformatf("out_address expected %08h got %08h",
                                    exp_r.address, m_axis_tdata));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MMU_ENABLE: mmu_on = cfg_data[0];
          REG_TABLE_BASE: tbl_base = cfg_data;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready)
        awaited_results.push_back(predict_walk_step(s_axis_tuser[0], s_axis_tdata[31:0],
                                                    s_axis_tdata[63:32]));
    end
    outstanding <= awaited_results.size();
  end

endmodule

[bench/two_level_page_table_walker_tb.sv]
// Testbench top for the page table walker: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module two_level_page_table_walker_tb;
  import ptw_pkg::*;

  // indexes that map to no register
  localparam logic [CFG_IDX_W-1:0] REG_RESERVED = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INVALID  = 2'd3;
  localparam int SETTLE_CYCLES = 8;
  localparam int SEG_ITEMS     = 156;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [63:0]          s_axis_tdata = '0;  // virtual_address, descriptor_data
  logic [0:0]           s_axis_tuser = '0;  // opcode
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [31:0]          m_axis_tdata;       // out_address
  logic [2:0]           m_axis_tuser;       // result_kind
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_data = '0;

  int mismatches;
  int outstanding;
  int idle_pct = 0;
  int stall_pct = 0;
  int items_sent = 0;

  two_level_page_table_walker uut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  two_level_page_table_walker_checker walk_checker (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // result side backpressure
  always @(posedge clk) m_axis_tready <= ($urandom_range(99) >= stall_pct);

  // mostly random words, with the all-zero and all-one extremes mixed in
  function automatic logic [31:0] rand_word();
    case ($urandom_range(7))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // one input beat; returns in the step of its handshake with tvalid still high
  task automatic send_item(input logic op, input logic [31:0] va, input logic [31:0] desc);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {desc, va};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    items_sent++;
  endtask

  // one register beat; the caller lowers cfg_valid after the last one
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic program_walker(input logic en, input logic [31:0] base);
    logic [31:0] en_word;
    en_word = $urandom;
    en_word[0] = en;
    if ($urandom_range(2) == 0) write_reg(REG_INVALID, rand_word());
    write_reg(REG_MMU_ENABLE, en_word);
    write_reg(REG_TABLE_BASE, base);
    cfg_valid <= 1'b0;
  endtask

  // stop sending and let every result come home
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // mostly complete walks with random descriptors, some noise beats
  task automatic random_walk();
    logic [31:0] d;
    logic [1:0]  t1;
    if ($urandom_range(99) < 15) begin
      send_item(1'($urandom_range(1)), rand_word(), rand_word());
    end else begin
      send_item(OP_TRANSLATE, rand_word(), rand_word());
      t1 = $urandom_range(1) ? DESC_COARSE : 2'($urandom_range(3));
      d = rand_word();
      d[1:0] = t1;
      send_item(OP_DESCRIPTOR, rand_word(), d);
      if (t1 == DESC_COARSE) begin
        d = rand_word();
        d[1:0] = 2'($urandom_range(3));
        send_item(OP_DESCRIPTOR, rand_word(), d);
      end
    end
  endtask

  initial begin
    int target;
    logic [31:0] base;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // registers still at reset: pass-through and a stray descriptor
    send_item(OP_TRANSLATE, 32'h0000_0000, 32'hFFFF_FFFF);
    send_item(OP_TRANSLATE, 32'hFFFF_FFFF, 32'h0000_0000);
    send_item(OP_DESCRIPTOR, 32'h1234_5678, 32'hFFFF_FFFE);
    drain();
    write_reg(REG_RESERVED, 32'hFFFF_FFFF);
    write_reg(REG_INVALID, 32'hFFFF_FFFF);
    write_reg(REG_MMU_ENABLE, 32'h0000_0001);
    write_reg(REG_TABLE_BASE, 32'hFFFF_FFFC);
    cfg_valid <= 1'b0;

    // section with fetch address wrapping past the top
    send_item(OP_TRANSLATE, 32'hFFFF_FFFF, 32'h0);
    send_item(OP_DESCRIPTOR, 32'h0, 32'hFFFF_FFFE);
    // coarse then small page
    send_item(OP_TRANSLATE, 32'h0000_0000, 32'h0);
    send_item(OP_DESCRIPTOR, 32'h0, 32'hFFFF_FFFD);
    send_item(OP_DESCRIPTOR, 32'h0, 32'hFFFF_FFFF);
    // coarse then second-level fault
    send_item(OP_TRANSLATE, 32'hFFFF_FFFF, 32'h0);
    send_item(OP_DESCRIPTOR, 32'h0, 32'hFFFF_FC01);
    send_item(OP_DESCRIPTOR, 32'hFFFF_FFFF, 32'hFFFF_FFFC);
    // first-level fault, then first-level type three passing through
    send_item(OP_TRANSLATE, 32'h8765_4321, 32'h0);
    send_item(OP_DESCRIPTOR, 32'h0, 32'hFFFF_FFFC);
    send_item(OP_TRANSLATE, 32'hDEAD_BEEF, 32'h0);
    send_item(OP_DESCRIPTOR, 32'h0, 32'h0000_0003);
    // coarse then a type-two second level
    send_item(OP_TRANSLATE, 32'h0012_3ABC, 32'h0);
    send_item(OP_DESCRIPTOR, 32'h0, 32'h4000_0401);
    send_item(OP_DESCRIPTOR, 32'h0, 32'h0000_0002);
    // request during a first-level wait, then a stray descriptor
    send_item(OP_TRANSLATE, 32'h1000_0000, 32'h0);
    send_item(OP_TRANSLATE, 32'h2000_0000, 32'h0);
    send_item(OP_DESCRIPTOR, 32'h0, 32'h0000_0002);
    // request during a second-level wait
    send_item(OP_TRANSLATE, 32'h3000_0000, 32'h0);
    send_item(OP_DESCRIPTOR, 32'h0, 32'h0000_0001);
    send_item(OP_TRANSLATE, 32'h4000_0000, 32'h0);

    // random phases under changing backpressure and settings
    for (int seg = 0; seg < 8; seg++) begin
      drain();
      case (seg % 4)
        0: begin idle_pct = 0;  stall_pct <= 0;  end
        1: begin idle_pct = 87; stall_pct <= 0;  end
        2: begin idle_pct = 0;  stall_pct <= 87; end
        default: begin idle_pct = 36; stall_pct <= 36; end
      endcase
      case (seg)
        0: base = 32'h0000_0000;
        1: base = 32'hFFFF_FFFF;
        5: base = 32'hFFFF_F000;
        default: base = $urandom;
      endcase
      program_walker((seg == 2 || seg == 6) ? 1'b0 : 1'b1, base);
      target = items_sent + SEG_ITEMS;
      while (items_sent < target) random_walk();
    end
    drain();

    if (mismatches == 0 && outstanding == 0) begin
      $display("two_level_page_table_walker regression: pass");
    end else begin
      $display("two_level_page_table_walker regression: fail");
    end
    $finish;
  end

  // hard stop far beyond the slowest correct run
  initial begin
    #5_000_000;
    $display("two_level_page_table_walker regression: fail");
    $finish;
  end

endmodule
